// ----- src/mtpe_pkg.sv -----
// Package for the mission transfer protocol engine.
// Holds the beat layouts, operation/action/result codes and the phase type.
// No dependencies.
package mtpe_pkg;

    // Transfer phase, one-hot.
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_DOWN = 3'b010,
        PH_UP   = 3'b100
    } phase_t;

    // Input operation codes.
    localparam logic [2:0] OP_REQ_LIST = 3'd0;
    localparam logic [2:0] OP_REQ_ITEM = 3'd1;
    localparam logic [2:0] OP_COUNT    = 3'd2;
    localparam logic [2:0] OP_ITEM     = 3'd3;
    localparam logic [2:0] OP_ACK      = 3'd4;
    localparam logic [2:0] OP_CLEAR    = 3'd5;
    localparam logic [2:0] OP_TICK     = 3'd6;

    // Result action codes.
    localparam logic [3:0] ACT_COUNT    = 4'd0;
    localparam logic [3:0] ACT_ITEM     = 4'd1;
    localparam logic [3:0] ACT_REQ      = 4'd2;
    localparam logic [3:0] ACT_ACK      = 4'd3;
    localparam logic [3:0] ACT_STORE    = 4'd4;
    localparam logic [3:0] ACT_CLEAR    = 4'd5;
    localparam logic [3:0] ACT_UPDONE   = 4'd6;
    localparam logic [3:0] ACT_DOWNDONE = 4'd7;
    localparam logic [3:0] ACT_FAILED   = 4'd8;
    localparam logic [3:0] ACT_TIMEOUT  = 4'd9;

    // Ack result codes.
    localparam logic [3:0] RES_ACCEPTED = 4'd0;
    localparam logic [3:0] RES_ERROR    = 4'd1;
    localparam logic [3:0] RES_NO_SPACE = 4'd4;
    localparam logic [3:0] RES_BAD_SEQ  = 4'd13;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SYSTEM    = 3'd0;
    localparam logic [2:0] CFG_COMPONENT = 3'd1;
    localparam logic [2:0] CFG_MISSION   = 3'd2;
    localparam logic [2:0] CFG_MAX_ITEMS = 3'd3;
    localparam logic [2:0] CFG_TIMEOUT   = 3'd4;

    // Configuration reset values.
    localparam logic [7:0]  RST_SYSTEM    = 8'd1;
    localparam logic [7:0]  RST_COMPONENT = 8'd1;
    localparam logic [7:0]  RST_MISSION   = 8'd0;
    localparam logic [15:0] RST_MAX_ITEMS = 16'd1024;
    localparam logic [31:0] RST_TIMEOUT   = 32'd30000;

    typedef struct packed {
        logic [7:0]  own_system_id;
        logic [7:0]  own_component_id;
        logic [7:0]  own_mission_type;
        logic [15:0] max_items;
        logic [31:0] timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  tgt_system;
        logic [7:0]  tgt_component;
        logic [7:0]  mission_kind;
        logic [15:0] sequence_req;
        logic [15:0] item_total;
        logic [7:0]  sender_system;
        logic [7:0]  sender_component;
        logic        ack_ok;
        logic [15:0] stored_count;
        logic [3:0]  backend_code;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  action;
        logic [15:0] index_or_count;
        logic [3:0]  ack_code;
    } result_t;

    // All results of one input item; every one goes to the same peer.
    typedef struct packed {
        result_t [2:0] res;
        logic [1:0]    cnt;
        logic [7:0]    dest_system;
        logic [7:0]    dest_component;
    } batch_t;

endpackage

// ----- src/mtpe_step.sv -----
// Transfer state registers and the single-pass decision logic of the engine.
// Uses mtpe_pkg for types and codes.
module mtpe_step (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               consume,
    input  mtpe_pkg::in_item_t item,
    input  mtpe_pkg::cfg_t     cfg,
    output mtpe_pkg::batch_t   batch
);

    mtpe_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       peer_sys_reg, peer_sys_next;
    logic [7:0]       peer_comp_reg, peer_comp_next;
    logic [15:0]      total_reg, total_next;
    logic [15:0]      next_idx_reg, next_idx_next;
    logic [31:0]      last_reg, last_next;

    logic        sys_ok;
    logic        comp_ok;
    logic        type_ok;
    logic        match_all;
    logic [15:0] idx_inc;
    logic [31:0] elapsed;

    assign sys_ok    = item.tgt_system == cfg.own_system_id;
    assign comp_ok   = (item.tgt_component == cfg.own_component_id) ||
                       (item.tgt_component == 8'd0);
    assign type_ok   = item.mission_kind == cfg.own_mission_type;
    assign match_all = sys_ok && comp_ok && type_ok;
    assign idx_inc   = next_idx_reg + 16'd1;
    assign elapsed   = item.now_ms - last_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        peer_sys_next  = peer_sys_reg;
        peer_comp_next = peer_comp_reg;
        total_next     = total_reg;
        next_idx_next  = next_idx_reg;
        last_next      = last_reg;
        batch.res      = '0;
        batch.cnt      = 2'd0;

        case (item.operation)
            mtpe_pkg::OP_REQ_LIST:
            begin
                if (match_all)
                begin
                    peer_sys_next  = item.sender_system;
                    peer_comp_next = item.sender_component;
                    total_next     = item.stored_count;
                    next_idx_next  = 16'd0;
                    last_next      = item.now_ms;
                    phase_next     = (item.stored_count != 16'd0) ? mtpe_pkg::PH_DOWN
                                                                  : mtpe_pkg::PH_IDLE;
                    batch.res[0]   = {mtpe_pkg::ACT_COUNT, item.stored_count,
                                      mtpe_pkg::RES_ACCEPTED};
                    batch.cnt      = 2'd1;
                end
            end
            mtpe_pkg::OP_REQ_ITEM:
            begin
                if (phase_reg != mtpe_pkg::PH_IDLE && sys_ok && type_ok)
                begin
                    batch.cnt = 2'd1;
                    if (item.sequence_req >= total_reg)
                    begin
                        batch.res[0]  = {mtpe_pkg::ACT_ACK, 16'd0, mtpe_pkg::RES_BAD_SEQ};
                        phase_next    = mtpe_pkg::PH_IDLE;
                        total_next    = 16'd0;
                        next_idx_next = 16'd0;
                    end
                    else
                    begin
                        last_next = item.now_ms;
                        if (item.backend_code != mtpe_pkg::RES_ACCEPTED)
                        begin
                            batch.res[0]  = {mtpe_pkg::ACT_ACK, 16'd0, item.backend_code};
                            phase_next    = mtpe_pkg::PH_IDLE;
                            total_next    = 16'd0;
                            next_idx_next = 16'd0;
                        end
                        else
                        begin
                            batch.res[0] = {mtpe_pkg::ACT_ITEM, item.sequence_req,
                                            mtpe_pkg::RES_ACCEPTED};
                        end
                    end
                end
            end
            mtpe_pkg::OP_COUNT:
            begin
                if (match_all)
                begin
                    if (item.item_total > cfg.max_items)
                    begin
                        // Refused before the peer is taken over.
                        batch.res[0] = {mtpe_pkg::ACT_ACK, 16'd0, mtpe_pkg::RES_NO_SPACE};
                        batch.cnt    = 2'd1;
                    end
                    else
                    begin
                        peer_sys_next  = item.sender_system;
                        peer_comp_next = item.sender_component;
                        total_next     = item.item_total;
                        next_idx_next  = 16'd0;
                        last_next      = item.now_ms;
                        batch.res[0]   = {mtpe_pkg::ACT_CLEAR, 16'd0, mtpe_pkg::RES_ACCEPTED};
                        batch.cnt      = 2'd2;
                        if (item.backend_code != mtpe_pkg::RES_ACCEPTED)
                        begin
                            batch.res[1] = {mtpe_pkg::ACT_ACK, 16'd0, item.backend_code};
                            phase_next   = mtpe_pkg::PH_IDLE;
                            total_next   = 16'd0;
                        end
                        else if (item.item_total == 16'd0)
                        begin
                            batch.res[1] = {mtpe_pkg::ACT_ACK, 16'd0, mtpe_pkg::RES_ACCEPTED};
                            phase_next   = mtpe_pkg::PH_IDLE;
                            total_next   = 16'd0;
                        end
                        else
                        begin
                            batch.res[1] = {mtpe_pkg::ACT_REQ, 16'd0, mtpe_pkg::RES_ACCEPTED};
                            phase_next   = mtpe_pkg::PH_UP;
                        end
                    end
                end
            end
            mtpe_pkg::OP_ITEM:
            begin
                if (phase_reg == mtpe_pkg::PH_UP && sys_ok && type_ok)
                begin
                    if (item.sequence_req != next_idx_reg)
                    begin
                        batch.res[0]  = {mtpe_pkg::ACT_ACK, 16'd0, mtpe_pkg::RES_BAD_SEQ};
                        batch.cnt     = 2'd1;
                        phase_next    = mtpe_pkg::PH_IDLE;
                        total_next    = 16'd0;
                        next_idx_next = 16'd0;
                    end
                    else
                    begin
                        last_next    = item.now_ms;
                        batch.res[0] = {mtpe_pkg::ACT_STORE, item.sequence_req,
                                        mtpe_pkg::RES_ACCEPTED};
                        batch.cnt    = 2'd2;
                        if (item.backend_code != mtpe_pkg::RES_ACCEPTED)
                        begin
                            batch.res[1]  = {mtpe_pkg::ACT_ACK, 16'd0, item.backend_code};
                            phase_next    = mtpe_pkg::PH_IDLE;
                            total_next    = 16'd0;
                            next_idx_next = 16'd0;
                        end
                        else if (idx_inc >= total_reg)
                        begin
                            batch.res[1]  = {mtpe_pkg::ACT_ACK, 16'd0, mtpe_pkg::RES_ACCEPTED};
                            batch.res[2]  = {mtpe_pkg::ACT_UPDONE, 16'd0,
                                             mtpe_pkg::RES_ACCEPTED};
                            batch.cnt     = 2'd3;
                            phase_next    = mtpe_pkg::PH_IDLE;
                            total_next    = 16'd0;
                            next_idx_next = 16'd0;
                        end
                        else
                        begin
                            batch.res[1]  = {mtpe_pkg::ACT_REQ, idx_inc, mtpe_pkg::RES_ACCEPTED};
                            next_idx_next = idx_inc;
                        end
                    end
                end
            end
            mtpe_pkg::OP_ACK:
            begin
                if (sys_ok && type_ok)
                begin
                    phase_next    = mtpe_pkg::PH_IDLE;
                    total_next    = 16'd0;
                    next_idx_next = 16'd0;
                    batch.res[0]  = {item.ack_ok ? mtpe_pkg::ACT_DOWNDONE : mtpe_pkg::ACT_FAILED,
                                     16'd0, mtpe_pkg::RES_ACCEPTED};
                    batch.cnt     = 2'd1;
                end
            end
            mtpe_pkg::OP_CLEAR:
            begin
                if (match_all)
                begin
                    batch.res[0] = {mtpe_pkg::ACT_CLEAR, 16'd0, mtpe_pkg::RES_ACCEPTED};
                    batch.res[1] = {mtpe_pkg::ACT_ACK, 16'd0, item.backend_code};
                    batch.cnt    = 2'd2;
                end
            end
            mtpe_pkg::OP_TICK:
            begin
                // The elapsed time wraps with the millisecond counter.
                if (phase_reg != mtpe_pkg::PH_IDLE && elapsed > cfg.timeout_ms)
                begin
                    batch.res[0]  = {mtpe_pkg::ACT_ACK, 16'd0, mtpe_pkg::RES_ERROR};
                    batch.res[1]  = {mtpe_pkg::ACT_TIMEOUT, 16'd0, mtpe_pkg::RES_ACCEPTED};
                    batch.cnt     = 2'd2;
                    phase_next    = mtpe_pkg::PH_IDLE;
                    total_next    = 16'd0;
                    next_idx_next = 16'd0;
                end
            end
            default:
            begin
                batch.cnt = 2'd0;
            end
        endcase

        batch.dest_system    = peer_sys_next;
        batch.dest_component = peer_comp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= mtpe_pkg::PH_IDLE;
            peer_sys_reg  <= 8'd0;
            peer_comp_reg <= 8'd0;
            total_reg     <= 16'd0;
            next_idx_reg  <= 16'd0;
            last_reg      <= 32'd0;
        end
        else if (consume)
        begin
            phase_reg     <= phase_next;
            peer_sys_reg  <= peer_sys_next;
            peer_comp_reg <= peer_comp_next;
            total_reg     <= total_next;
            next_idx_reg  <= next_idx_next;
            last_reg      <= last_next;
        end
    end

`ifndef SYNTHESIS
    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("phase register lost its one-hot code");

    a_active_has_items: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != mtpe_pkg::PH_IDLE |-> total_reg != 16'd0)
        else $error("active transfer with zero items");

    a_upload_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == mtpe_pkg::PH_UP |-> next_idx_reg < total_reg)
        else $error("upload index ran past the item count");
`endif

endmodule

// ----- src/mission_transfer_protocol_engine_top.sv -----
// Top level of the mission transfer protocol engine: stream ports, configuration
// registers, input register and result buffer. Uses mtpe_pkg and mtpe_step.
//
// An input beat is registered in the input register, and its results are then registered
// in the result buffer, from which the first result beat can be taken.
// Throughput: one input beat per cycle while each item yields at most one result and
// m_tready is high; an item with k results (k up to 3) leaves as k beats, one per cycle.
// Reset (rst_n, asynchronous, active low) clears the transfer state, both valid flags
// and loads the configuration defaults; no clearing pass is needed.
module mission_transfer_protocol_engine_top (
    input  logic         clk,
    input  logic         rst_n,
    // Configuration write port.
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata,
    // Input stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    // tgt_system, tgt_component, mission_kind, sequence_req, item_total,
    // sender_system, sender_component, ack_ok, stored_count, backend_code, now_ms
    input  logic [127:0] s_tdata,
    input  logic [2:0]   s_tuser,   // operation
    // Result stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    // dest_system, dest_component, index_or_count, ack_code
    output logic [39:0]  m_tdata,
    output logic [3:0]   m_tuser,   // action
    output logic         m_tlast
);

    mtpe_pkg::cfg_t     cfg_reg;
    mtpe_pkg::in_item_t in_item;
    mtpe_pkg::in_item_t in_item_reg;
    logic               in_valid_reg;
    mtpe_pkg::batch_t   batch;
    mtpe_pkg::batch_t   batch_reg;
    logic [1:0]         pos_reg;
    logic               buf_free;
    logic               consume;
    mtpe_pkg::result_t  cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_system_id    <= mtpe_pkg::RST_SYSTEM;
            cfg_reg.own_component_id <= mtpe_pkg::RST_COMPONENT;
            cfg_reg.own_mission_type <= mtpe_pkg::RST_MISSION;
            cfg_reg.max_items        <= mtpe_pkg::RST_MAX_ITEMS;
            cfg_reg.timeout_ms       <= mtpe_pkg::RST_TIMEOUT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                mtpe_pkg::CFG_SYSTEM:    cfg_reg.own_system_id    <= cfg_wdata[7:0];
                mtpe_pkg::CFG_COMPONENT: cfg_reg.own_component_id <= cfg_wdata[7:0];
                mtpe_pkg::CFG_MISSION:   cfg_reg.own_mission_type <= cfg_wdata[7:0];
                mtpe_pkg::CFG_MAX_ITEMS: cfg_reg.max_items        <= cfg_wdata[15:0];
                mtpe_pkg::CFG_TIMEOUT:   cfg_reg.timeout_ms       <= cfg_wdata;
                default:                 cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    assign in_item.operation        = s_tuser;
    assign in_item.tgt_system       = s_tdata[7:0];
    assign in_item.tgt_component    = s_tdata[15:8];
    assign in_item.mission_kind     = s_tdata[23:16];
    assign in_item.sequence_req     = s_tdata[39:24];
    assign in_item.item_total       = s_tdata[55:40];
    assign in_item.sender_system    = s_tdata[63:56];
    assign in_item.sender_component = s_tdata[71:64];
    assign in_item.ack_ok           = s_tdata[72];
    assign in_item.stored_count     = s_tdata[88:73];
    assign in_item.backend_code     = s_tdata[92:89];
    assign in_item.now_ms           = s_tdata[124:93];

    // The result buffer can take a new batch when it is drained or its last
    // beat leaves in this cycle.
    assign buf_free = (pos_reg == batch_reg.cnt) ||
                      ((pos_reg + 2'd1 == batch_reg.cnt) && m_tready);
    assign consume  = in_valid_reg && buf_free;
    assign s_tready = !in_valid_reg || buf_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= in_item;
        end
    end

    mtpe_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .consume (consume),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .batch   (batch)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_reg <= '0;
            pos_reg   <= 2'd0;
        end
        else if (consume)
        begin
            batch_reg <= batch;
            pos_reg   <= 2'd0;
        end
        else if (m_tvalid && m_tready)
        begin
            pos_reg <= pos_reg + 2'd1;
        end
    end

    always_comb
    begin
        case (pos_reg)
            2'd1:    cur = batch_reg.res[1];
            2'd2:    cur = batch_reg.res[2];
            default: cur = batch_reg.res[0];
        endcase
    end

    assign m_tvalid = pos_reg != batch_reg.cnt;
    assign m_tlast  = (pos_reg + 2'd1) == batch_reg.cnt;
    assign m_tuser  = cur.action;
    assign m_tdata  = {4'd0, cur.ack_code, cur.index_or_count,
                       batch_reg.dest_component, batch_reg.dest_system};

`ifndef SYNTHESIS
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= batch_reg.cnt)
        else $error("result position beyond batch size");

    a_drain_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast && !consume) |=> !m_tvalid)
        else $error("result beat shown after the last one of its batch");

    a_last_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tlast |-> m_tvalid)
        else $error("last flag raised without a valid result beat");
`endif

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for mission_transfer_protocol_engine_top.
// Drives mission messages and ticks, predicts each answer beat in a small tracker class.
// Depends on mtpe_pkg and the RTL under src.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]  action;
        logic [7:0]  dest_system;
        logic [7:0]  dest_component;
        logic [15:0] index_or_count;
        logic [3:0]  ack_code;
        logic        is_last;
    } action_beat_t;

    // Tracks the vehicle-side transfer state and the answers it owes the link.
    class transfer_tracker;
        logic [7:0]       own_system;
        logic [7:0]       own_component;
        logic [7:0]       own_kind;
        logic [15:0]      max_items;
        logic [31:0]      timeout_ms;
        mtpe_pkg::phase_t phase;
        logic [7:0]       peer_system;
        logic [7:0]       peer_component;
        logic [15:0]      total_items;
        logic [15:0]      next_index;
        logic [31:0]      last_activity;
        action_beat_t     owed_actions[$];
        int               errors;

        function new();
            own_system     = mtpe_pkg::RST_SYSTEM;
            own_component  = mtpe_pkg::RST_COMPONENT;
            own_kind       = mtpe_pkg::RST_MISSION;
            max_items      = mtpe_pkg::RST_MAX_ITEMS;
            timeout_ms     = mtpe_pkg::RST_TIMEOUT;
            phase          = mtpe_pkg::PH_IDLE;
            peer_system    = '0;
            peer_component = '0;
            total_items    = '0;
            next_index     = '0;
            last_activity  = '0;
            errors         = 0;
        endfunction

        function void set_reg(logic [2:0] addr, logic [31:0] value);
            case (addr)
                mtpe_pkg::CFG_SYSTEM:    own_system    = value[7:0];
                mtpe_pkg::CFG_COMPONENT: own_component = value[7:0];
                mtpe_pkg::CFG_MISSION:   own_kind      = value[7:0];
                mtpe_pkg::CFG_MAX_ITEMS: max_items     = value[15:0];
                mtpe_pkg::CFG_TIMEOUT:   timeout_ms    = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return owed_actions.size();
        endfunction

        function void owe(logic [3:0] act, logic [15:0] idx, logic [3:0] code);
            action_beat_t b;
            b.action         = act;
            b.dest_system    = peer_system;
            b.dest_component = peer_component;
            b.index_or_count = idx;
            b.ack_code       = code;
            b.is_last        = 1'b0;
            owed_actions.push_back(b);
        endfunction

        function void abort_transfer();
            phase       = mtpe_pkg::PH_IDLE;
            total_items = '0;
            next_index  = '0;
        endfunction

        // Applies one accepted message and returns how many beats it causes.
        function int note_message(mtpe_pkg::in_item_t m);
            int           first;
            bit           sys_ok;
            bit           comp_ok;
            bit           kind_ok;
            logic [31:0]  idle_ms;
            action_beat_t tail;
            first   = owed_actions.size();
            sys_ok  = m.tgt_system == own_system;
            comp_ok = m.tgt_component == own_component || m.tgt_component == 8'd0;
            kind_ok = m.mission_kind == own_kind;
            case (m.operation)
                mtpe_pkg::OP_REQ_LIST:
                begin
                    if (sys_ok && comp_ok && kind_ok)
                    begin
                        peer_system    = m.sender_system;
                        peer_component = m.sender_component;
                        total_items    = m.stored_count;
                        next_index     = '0;
                        last_activity  = m.now_ms;
                        owe(mtpe_pkg::ACT_COUNT, total_items, mtpe_pkg::RES_ACCEPTED);
                        phase = (total_items != 0) ? mtpe_pkg::PH_DOWN : mtpe_pkg::PH_IDLE;
                    end
                end
                mtpe_pkg::OP_REQ_ITEM:
                begin
                    if (phase != mtpe_pkg::PH_IDLE && sys_ok && kind_ok)
                    begin
                        if (m.sequence_req >= total_items)
                        begin
                            owe(mtpe_pkg::ACT_ACK, '0, mtpe_pkg::RES_BAD_SEQ);
                            abort_transfer();
                        end
                        else
                        begin
                            last_activity = m.now_ms;
                            if (m.backend_code != mtpe_pkg::RES_ACCEPTED)
                            begin
                                owe(mtpe_pkg::ACT_ACK, '0, m.backend_code);
                                abort_transfer();
                            end
                            else
                            begin
                                owe(mtpe_pkg::ACT_ITEM, m.sequence_req,
                                    mtpe_pkg::RES_ACCEPTED);
                            end
                        end
                    end
                end
                mtpe_pkg::OP_COUNT:
                begin
                    if (sys_ok && comp_ok && kind_ok)
                    begin
                        if (m.item_total > max_items)
                        begin
                            // Refusal goes to the old peer and leaves the transfer alone.
                            owe(mtpe_pkg::ACT_ACK, '0, mtpe_pkg::RES_NO_SPACE);
                        end
                        else
                        begin
                            peer_system    = m.sender_system;
                            peer_component = m.sender_component;
                            total_items    = m.item_total;
                            next_index     = '0;
                            last_activity  = m.now_ms;
                            owe(mtpe_pkg::ACT_CLEAR, '0, mtpe_pkg::RES_ACCEPTED);
                            if (m.backend_code != mtpe_pkg::RES_ACCEPTED)
                            begin
                                owe(mtpe_pkg::ACT_ACK, '0, m.backend_code);
                                abort_transfer();
                            end
                            else if (m.item_total == 0)
                            begin
                                owe(mtpe_pkg::ACT_ACK, '0, mtpe_pkg::RES_ACCEPTED);
                                abort_transfer();
                            end
                            else
                            begin
                                owe(mtpe_pkg::ACT_REQ, '0, mtpe_pkg::RES_ACCEPTED);
                                phase = mtpe_pkg::PH_UP;
                            end
                        end
                    end
                end
                mtpe_pkg::OP_ITEM:
                begin
                    if (phase == mtpe_pkg::PH_UP && sys_ok && kind_ok)
                    begin
                        if (m.sequence_req != next_index)
                        begin
                            owe(mtpe_pkg::ACT_ACK, '0, mtpe_pkg::RES_BAD_SEQ);
                            abort_transfer();
                        end
                        else
                        begin
                            last_activity = m.now_ms;
                            owe(mtpe_pkg::ACT_STORE, m.sequence_req, mtpe_pkg::RES_ACCEPTED);
                            if (m.backend_code != mtpe_pkg::RES_ACCEPTED)
                            begin
                                owe(mtpe_pkg::ACT_ACK, '0, m.backend_code);
                                abort_transfer();
                            end
                            else
                            begin
                                next_index = next_index + 16'd1;
                                if (next_index >= total_items)
                                begin
                                    owe(mtpe_pkg::ACT_ACK, '0, mtpe_pkg::RES_ACCEPTED);
                                    abort_transfer();
                                    owe(mtpe_pkg::ACT_UPDONE, '0, mtpe_pkg::RES_ACCEPTED);
                                end
                                else
                                begin
                                    owe(mtpe_pkg::ACT_REQ, next_index, mtpe_pkg::RES_ACCEPTED);
                                end
                            end
                        end
                    end
                end
                mtpe_pkg::OP_ACK:
                begin
                    if (sys_ok && kind_ok)
                    begin
                        abort_transfer();
                        owe(m.ack_ok ? mtpe_pkg::ACT_DOWNDONE : mtpe_pkg::ACT_FAILED, '0,
                            mtpe_pkg::RES_ACCEPTED);
                    end
                end
                mtpe_pkg::OP_CLEAR:
                begin
                    if (sys_ok && comp_ok && kind_ok)
                    begin
                        owe(mtpe_pkg::ACT_CLEAR, '0, mtpe_pkg::RES_ACCEPTED);
                        owe(mtpe_pkg::ACT_ACK, '0, m.backend_code);
                    end
                end
                mtpe_pkg::OP_TICK:
                begin
                    if (phase != mtpe_pkg::PH_IDLE)
                    begin
                        idle_ms = m.now_ms - last_activity;
                        if (idle_ms > timeout_ms)
                        begin
                            owe(mtpe_pkg::ACT_ACK, '0, mtpe_pkg::RES_ERROR);
                            abort_transfer();
                            owe(mtpe_pkg::ACT_TIMEOUT, '0, mtpe_pkg::RES_ACCEPTED);
                        end
                    end
                end
                default: ;
            endcase
            if (owed_actions.size() > first)
            begin
                tail = owed_actions.pop_back();
                tail.is_last = 1'b1;
                owed_actions.push_back(tail);
            end
            return owed_actions.size() - first;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_action(action_beat_t got);
            action_beat_t want;
            if (owed_actions.size() == 0)
            begin
                report($sformatf("beat with action %0d while nothing is owed", got.action));
                return;
            end
            want = owed_actions.pop_front();
            if (got.action != want.action)
                report($sformatf("action %0d, want %0d", got.action, want.action));
            if (got.dest_system != want.dest_system)
                report($sformatf("dest_system %0d, want %0d",
                                 got.dest_system, want.dest_system));
            if (got.dest_component != want.dest_component)
                report($sformatf("dest_component %0d, want %0d",
                                 got.dest_component, want.dest_component));
            if (got.index_or_count != want.index_or_count)
                report($sformatf("index_or_count %0d, want %0d",
                                 got.index_or_count, want.index_or_count));
            if (got.ack_code != want.ack_code)
                report($sformatf("ack_code %0d, want %0d", got.ack_code, want.ack_code));
            if (got.is_last != want.is_last)
                report($sformatf("tlast %0b, want %0b", got.is_last, want.is_last));
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [2:0]   cfg_addr;
    logic [31:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;
    logic [3:0]   m_tuser;
    logic         m_tlast;

    transfer_tracker tracker;
    logic [31:0]     clock_ms;
    int              sent_msgs;
    int              send_idle_pct;
    int              recv_idle_pct;

    mission_transfer_protocol_engine_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_action({m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[31:16],
                                  m_tdata[35:32], m_tlast});
    end

    initial
    begin
        #5ms;
        $display("mission_transfer_protocol_engine_top verification failed");
        $finish;
    end

    // A message with random payload; noisy ones are sometimes misaddressed or refused by
    // the store, clean ones are addressed exactly to this vehicle.
    function automatic mtpe_pkg::in_item_t make_msg(logic [2:0] op, bit noisy);
        mtpe_pkg::in_item_t m;
        m = {$urandom, $urandom, $urandom, $urandom};
        m.operation     = op;
        m.tgt_system    = tracker.own_system;
        m.tgt_component = tracker.own_component;
        m.mission_kind  = tracker.own_kind;
        m.backend_code  = mtpe_pkg::RES_ACCEPTED;
        if (noisy)
        begin
            if ($urandom_range(0, 14) == 0)
                m.tgt_system = 8'($urandom);
            if ($urandom_range(0, 3) == 0)
                m.tgt_component = 8'd0;
            else if ($urandom_range(0, 14) == 0)
                m.tgt_component = 8'($urandom);
            if ($urandom_range(0, 14) == 0)
                m.mission_kind = 8'($urandom);
            if ($urandom_range(0, 7) == 0)
                m.backend_code = 4'($urandom_range(1, 15));
        end
        clock_ms = clock_ms + $urandom_range(0, 40);
        m.now_ms = clock_ms;
        return m;
    endfunction

    // Entered and left at a falling edge; s_tvalid stays high after the beat so that a
    // following message can go out back to back.
    task automatic send_msg(mtpe_pkg::in_item_t m);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= m.operation;
        s_tdata  <= {3'b000, m.now_ms, m.backend_code, m.stored_count, m.ack_ok,
                     m.sender_component, m.sender_system, m.item_total, m.sequence_req,
                     m.mission_kind, m.tgt_component, m.tgt_system};
        do @(posedge clk); while (!s_tready);
        void'(tracker.note_message(m));
        sent_msgs++;
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (tracker.pending() != 0)
            @(negedge clk);
    endtask

    task automatic apply_settings(logic [7:0] sys, logic [7:0] comp, logic [7:0] kind,
                                  logic [15:0] max_cnt, logic [31:0] tmo);
        logic [31:0] values[5];
        values = '{{24'd0, sys}, {24'd0, comp}, {24'd0, kind}, {16'd0, max_cnt}, tmo};
        drain();
        // Filtered messages cause no beat but may still be in flight.
        repeat (8) @(negedge clk);
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= i[2:0];
            cfg_wdata <= values[i];
            tracker.set_reg(i[2:0], values[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        clock_ms = $urandom;
    endtask

    task automatic tick_near_timeout();
        mtpe_pkg::in_item_t m;
        logic [31:0]        deadline;
        m = make_msg(mtpe_pkg::OP_TICK, 1'b1);
        deadline = tracker.last_activity + tracker.timeout_ms;
        case ($urandom_range(0, 3))
            0: m.now_ms = deadline;
            1: m.now_ms = deadline + 32'd1;
            2: m.now_ms = $urandom;
            default: m.now_ms = deadline + $urandom_range(2, 1000);
        endcase
        clock_ms = m.now_ms;
        send_msg(m);
    endtask

    task automatic random_session();
        mtpe_pkg::in_item_t m;
        int                 pick;
        int                 steps;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            m = make_msg(mtpe_pkg::OP_REQ_LIST, 1'b1);
            m.stored_count = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                             16'($urandom_range(0, 6));
            send_msg(m);
            if ($urandom_range(0, 7) == 0)
                drain();
            repeat ($urandom_range(1, 5))
            begin
                m = make_msg(mtpe_pkg::OP_REQ_ITEM, 1'b1);
                if ($urandom_range(0, 9) != 0)
                    m.sequence_req = 16'($urandom_range(0, tracker.total_items));
                send_msg(m);
            end
            if ($urandom_range(0, 2) != 0)
                send_msg(make_msg(mtpe_pkg::OP_ACK, 1'b1));
        end
        else if (pick < 70)
        begin
            m = make_msg(mtpe_pkg::OP_COUNT, 1'b1);
            m.item_total = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                           16'($urandom_range(0, 6));
            send_msg(m);
            steps = 0;
            while (tracker.phase == mtpe_pkg::PH_UP && steps < 12)
            begin
                m = make_msg(mtpe_pkg::OP_ITEM, 1'b1);
                if ($urandom_range(0, 14) != 0)
                    m.sequence_req = tracker.next_index;
                send_msg(m);
                steps++;
            end
        end
        else if (pick < 80)
        begin
            send_msg(make_msg(mtpe_pkg::OP_CLEAR, 1'b1));
        end
        else if (pick < 92)
        begin
            if (tracker.phase == mtpe_pkg::PH_IDLE)
            begin
                m = make_msg(mtpe_pkg::OP_REQ_LIST, 1'b0);
                m.stored_count = 16'($urandom_range(1, 4));
                send_msg(m);
            end
            tick_near_timeout();
        end
        else
        begin
            m = make_msg(mtpe_pkg::OP_TICK, 1'b0);
            m = {$urandom, $urandom, $urandom, $urandom};
            m.operation = 3'($urandom_range(0, 7));
            send_msg(m);
        end
    endtask

    task automatic directed_checks();
        mtpe_pkg::in_item_t m;
        // Download: one item served, then a store refusal aborts.
        m = make_msg(mtpe_pkg::OP_REQ_LIST, 1'b0);
        m.stored_count = 3; m.sender_system = 8'hFF; m.sender_component = 8'h00;
        send_msg(m);
        m = make_msg(mtpe_pkg::OP_REQ_ITEM, 1'b0); m.sequence_req = 0; send_msg(m);
        m = make_msg(mtpe_pkg::OP_REQ_ITEM, 1'b0); m.sequence_req = 2; m.backend_code = 4'hF;
        send_msg(m);
        m = make_msg(mtpe_pkg::OP_REQ_LIST, 1'b0); m.stored_count = 0; send_msg(m);
        // Request while idle is dropped.
        m = make_msg(mtpe_pkg::OP_REQ_ITEM, 1'b0); m.sequence_req = 0; send_msg(m);
        // Upload corner cases: too many (refused), empty, store error.
        m = make_msg(mtpe_pkg::OP_COUNT, 1'b0); m.item_total = 16'hFFFF; send_msg(m);
        m = make_msg(mtpe_pkg::OP_COUNT, 1'b0); m.item_total = 0; send_msg(m);
        m = make_msg(mtpe_pkg::OP_COUNT, 1'b0); m.item_total = 2; m.backend_code = 4'd3;
        send_msg(m);
        // Upload with an out-of-order item, then a clean two-item upload.
        m = make_msg(mtpe_pkg::OP_COUNT, 1'b0); m.item_total = 2; send_msg(m);
        m = make_msg(mtpe_pkg::OP_ITEM, 1'b0); m.sequence_req = 1; send_msg(m);
        m = make_msg(mtpe_pkg::OP_COUNT, 1'b0); m.item_total = 2; m.sender_system = 8'h00;
        m.sender_component = 8'hFF;
        send_msg(m);
        m = make_msg(mtpe_pkg::OP_ITEM, 1'b0); m.sequence_req = 0; send_msg(m);
        m = make_msg(mtpe_pkg::OP_ITEM, 1'b0); m.sequence_req = 1; send_msg(m);
        // Count right at the limit, then the store refuses the first item.
        m = make_msg(mtpe_pkg::OP_COUNT, 1'b0); m.item_total = mtpe_pkg::RST_MAX_ITEMS;
        send_msg(m);
        m = make_msg(mtpe_pkg::OP_ITEM, 1'b0); m.sequence_req = 0; m.backend_code = 4'd9;
        send_msg(m);
        // Largest list with time wrapping past zero, then an index past the end.
        m = make_msg(mtpe_pkg::OP_REQ_LIST, 1'b0); m.stored_count = 16'hFFFF;
        m.now_ms = 32'hFFFF_FFF0;
        send_msg(m);
        m = make_msg(mtpe_pkg::OP_TICK, 1'b0); m.now_ms = 32'h0000_0010; send_msg(m);
        m = make_msg(mtpe_pkg::OP_REQ_ITEM, 1'b0); m.sequence_req = 16'hFFFF; send_msg(m);
        // Timeout boundary: equal to the limit holds, one more aborts.
        m = make_msg(mtpe_pkg::OP_REQ_LIST, 1'b0); m.stored_count = 5; m.now_ms = 32'd100;
        send_msg(m);
        m = make_msg(mtpe_pkg::OP_TICK, 1'b0); m.now_ms = 32'd100 + mtpe_pkg::RST_TIMEOUT;
        send_msg(m);
        m = make_msg(mtpe_pkg::OP_TICK, 1'b0); m.now_ms = 32'd101 + mtpe_pkg::RST_TIMEOUT;
        send_msg(m);
        m = make_msg(mtpe_pkg::OP_ACK, 1'b0); m.ack_ok = 1'b1; send_msg(m);
        m = make_msg(mtpe_pkg::OP_ACK, 1'b0); m.ack_ok = 1'b0; send_msg(m);
        m = make_msg(mtpe_pkg::OP_CLEAR, 1'b0); m.backend_code = 4'hF; send_msg(m);
        m = make_msg(mtpe_pkg::OP_TICK, 1'b0); m.operation = 3'd7; send_msg(m);
        // Addressing: broadcast component passes, wrong system or kind is dropped.
        m = make_msg(mtpe_pkg::OP_REQ_LIST, 1'b0); m.tgt_component = 8'd0;
        m.stored_count = 0;
        send_msg(m);
        m = make_msg(mtpe_pkg::OP_REQ_LIST, 1'b0);
        m.tgt_system = mtpe_pkg::RST_SYSTEM + 8'd1;
        send_msg(m);
        m = make_msg(mtpe_pkg::OP_COUNT, 1'b0);
        m.mission_kind = mtpe_pkg::RST_MISSION + 8'd1;
        send_msg(m);
    endtask

    initial
    begin
        int target;
        tracker       = new();
        clock_ms      = $urandom;
        sent_msgs     = 0;
        send_idle_pct = 25;
        recv_idle_pct = 75;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed_checks();

        target = 0;
        for (int setting = 0; setting < 6; setting++)
        begin
            case (setting)
                0: ;
                1: apply_settings(8'd0, 8'd0, 8'd0, 16'd0, 32'd1);
                2: apply_settings(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
                3: apply_settings(8'($urandom), 8'($urandom), 8'($urandom_range(0, 2)),
                                  16'd8, 32'd500);
                4: apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 16'd3, 32'd40);
                default: apply_settings(mtpe_pkg::RST_SYSTEM, mtpe_pkg::RST_COMPONENT,
                                        mtpe_pkg::RST_MISSION, mtpe_pkg::RST_MAX_ITEMS,
                                        mtpe_pkg::RST_TIMEOUT);
            endcase
            if (setting == 2)
            begin
                send_idle_pct = 75;
                recv_idle_pct = 25;
            end
            else if (setting == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            target += 55;
            while (sent_msgs < target)
                random_session();
        end

        drain();
        repeat (20) @(negedge clk);
        if (tracker.pending() != 0)
            tracker.report($sformatf("%0d beats never arrived", tracker.pending()));
        if (tracker.errors == 0)
            $display("mission_transfer_protocol_engine_top verification clean");
        else
            $display("mission_transfer_protocol_engine_top verification failed");
        $finish;
    end

endmodule
